// ===== rtl/core/pcomp_pkg.sv =====
// ----------------------------------------------------------------------------
// pcomp_pkg
// Shared word type and sizes for the pressure compensation datapath.
// ----------------------------------------------------------------------------
package pcomp_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned HalfW = WordW / 2;

  typedef logic [WordW-1:0] word_t;

endpackage

// ===== rtl/core/pcomp_mul64.sv =====
// ----------------------------------------------------------------------------
// pcomp_mul64
// Two-stage multiplier giving the low 64 bits of a product (wraps mod 2^64).
// ----------------------------------------------------------------------------
module pcomp_mul64 (
  input  logic               clk,
  input  pcomp_pkg::word_t   a,
  input  pcomp_pkg::word_t   b,
  output pcomp_pkg::word_t   prod
);

  localparam int unsigned H = pcomp_pkg::HalfW;

  pcomp_pkg::word_t ll;
  logic [H-1:0]     lh;
  logic [H-1:0]     hl;

  // cross terms only reach the upper half, so keep their low halves
  always_ff @(posedge clk) begin
    ll   <= a[H-1:0] * b[H-1:0];
    lh   <= a[H-1:0] * b[2*H-1:H];
    hl   <= a[2*H-1:H] * b[H-1:0];
    prod <= ll + {lh + hl, {H{1'b0}}};
  end

endmodule

// ===== rtl/core/pcomp_div.sv =====
// ----------------------------------------------------------------------------
// pcomp_div
// Pipelined signed 64-bit divider, truncating toward zero, one quotient bit
// per stage. Carries a valid bit and a zero-divisor flag alongside.
// ----------------------------------------------------------------------------
module pcomp_div (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_vld,
  input  logic             in_zero,
  input  pcomp_pkg::word_t num,
  input  pcomp_pkg::word_t den,
  output logic             out_vld,
  output logic             out_zero,
  output pcomp_pkg::word_t quo
);

  localparam int unsigned W = pcomp_pkg::WordW;

  pcomp_pkg::word_t rem [W+1];
  pcomp_pkg::word_t nq  [W+1];
  pcomp_pkg::word_t dv  [W+1];
  logic             neg [W+1];
  logic             vld [W+1];
  logic             zro [W+1];

  // stage 0: take magnitudes
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_vld;
    end
    zro[0] <= in_zero;
    rem[0] <= '0;
    nq[0]  <= num[W-1] ? (~num + 1'b1) : num;
    dv[0]  <= den[W-1] ? (~den + 1'b1) : den;
    neg[0] <= num[W-1] ^ den[W-1];
  end

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [W:0] trial;
    logic [W:0] diff;
    logic       qbit;

    assign trial = {rem[k], nq[k][W-1]};
    assign diff  = trial - {1'b0, dv[k]};
    assign qbit  = ~diff[W];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
      zro[k+1] <= zro[k];
      rem[k+1] <= qbit ? diff[W-1:0] : trial[W-1:0];
      nq[k+1]  <= {nq[k][W-2:0], qbit};
      dv[k+1]  <= dv[k];
      neg[k+1] <= neg[k];
    end
  end

  // restore the sign; min / -1 wraps by itself
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= vld[W];
    end
    out_zero <= zro[W];
    quo      <= neg[W] ? (~nq[W] + 1'b1) : nq[W];
  end

endmodule

// ===== rtl/core/pressure_compensation_int64.sv =====
// ----------------------------------------------------------------------------
// pressure_compensation_int64
// 64-bit integer barometric pressure compensation, fully pipelined.
// ----------------------------------------------------------------------------
//  channel   signals                                       transfer when
//  -------   --------------------------------------------  ----------------
//  input     start, busy, raw_pressure, fine_temperature   start & !busy
//  result    done, pressure_milli_pa, zero_divisor         done
//  config    cfg_we, cfg_index, cfg_wdata                  cfg_we
//
//  One sample enters per cycle; each result passes from its transfer through
//  the multipliers ahead of the bit-per-stage divider, the divider itself and
//  the multipliers behind it. busy stays low. Reset clears the valid pipeline
//  and the coefficients. The receiver cannot stall, so the pipeline advances
//  every cycle.
// ----------------------------------------------------------------------------
module pressure_compensation_int64 (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [19:0] raw_pressure,
  input  logic signed [31:0] fine_temperature,
  output logic        done,
  output logic [31:0] pressure_milli_pa,
  output logic        zero_divisor,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam logic [3:0] RegP1   = 4'd0;
  localparam logic [3:0] RegP2   = 4'd1;
  localparam logic [3:0] RegP3   = 4'd2;
  localparam logic [3:0] RegP4   = 4'd3;
  localparam logic [3:0] RegP5   = 4'd4;
  localparam logic [3:0] RegP6   = 4'd5;
  localparam logic [3:0] RegP7   = 4'd6;
  localparam logic [3:0] RegP8P9 = 4'd7;

  localparam pcomp_pkg::word_t TempOff = 64'd128000;
  localparam pcomp_pkg::word_t RawFull = 64'd1048576;
  localparam pcomp_pkg::word_t DivBias = 64'd1 << 47;
  localparam pcomp_pkg::word_t Scale   = 64'd3125;

  typedef pcomp_pkg::word_t word_t;

  logic [15:0] cal_p1, cal_p2, cal_p3, cal_p4, cal_p5, cal_p6, cal_p7;
  logic [31:0] cal_p8_p9;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_p1    <= '0;
      cal_p2    <= '0;
      cal_p3    <= '0;
      cal_p4    <= '0;
      cal_p5    <= '0;
      cal_p6    <= '0;
      cal_p7    <= '0;
      cal_p8_p9 <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegP1:   cal_p1    <= cfg_wdata[15:0];
        RegP2:   cal_p2    <= cfg_wdata[15:0];
        RegP3:   cal_p3    <= cfg_wdata[15:0];
        RegP4:   cal_p4    <= cfg_wdata[15:0];
        RegP5:   cal_p5    <= cfg_wdata[15:0];
        RegP6:   cal_p6    <= cfg_wdata[15:0];
        RegP7:   cal_p7    <= cfg_wdata[15:0];
        RegP8P9: cal_p8_p9 <= cfg_wdata;
        default: ;
      endcase
    end
  end

  word_t sx_p2, sx_p3, sx_p4, sx_p5, sx_p6, sx_p7, sx_p8, sx_p9, zx_p1;
  assign zx_p1 = {48'd0, cal_p1};
  assign sx_p2 = {{48{cal_p2[15]}}, cal_p2};
  assign sx_p3 = {{48{cal_p3[15]}}, cal_p3};
  assign sx_p4 = {{48{cal_p4[15]}}, cal_p4};
  assign sx_p5 = {{48{cal_p5[15]}}, cal_p5};
  assign sx_p6 = {{48{cal_p6[15]}}, cal_p6};
  assign sx_p7 = {{48{cal_p7[15]}}, cal_p7};
  assign sx_p8 = {{48{cal_p8_p9[15]}}, cal_p8_p9[15:0]};
  assign sx_p9 = {{48{cal_p8_p9[31]}}, cal_p8_p9[31:16]};

  assign busy = 1'b0;

  // front end: stages 0..9
  logic        v0;
  logic [9:1]  vpre;
  word_t       t0;
  logic [19:0] raw0;
  word_t       a1, pr1, pr2, pr3, pr4, pr5, pr6;
  word_t       aa3, ap5_3, ap2_3, ap5_4, ap2_4, ap5_5, ap2_5;
  word_t       m6_5, m3_5;
  word_t       bb6, vv6, num7;
  word_t       dprod8, d9, n9;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0   <= 1'b0;
      vpre <= '0;
    end else begin
      v0   <= start & ~busy;
      vpre <= {vpre[8:1], v0};
    end
    t0    <= {{32{fine_temperature[31]}}, fine_temperature};
    raw0  <= raw_pressure;
    a1    <= t0 - TempOff;
    pr1   <= RawFull - {44'd0, raw0};
    pr2   <= pr1;
    pr3   <= pr2;
    pr4   <= pr3;
    pr5   <= pr4;
    pr6   <= pr5;
    ap5_4 <= ap5_3;
    ap2_4 <= ap2_3;
    ap5_5 <= ap5_4;
    ap2_5 <= ap2_4;
    bb6   <= m6_5 + (ap5_5 << 17) + (sx_p4 << 35);
    vv6   <= word_t'($signed(m3_5) >>> 8) + (ap2_5 << 12) + DivBias;
    num7  <= (pr6 << 31) - bb6;
    d9    <= word_t'($signed(dprod8) >>> 33);
  end

  pcomp_mul64 u_aa  (.clk(clk), .a(a1),   .b(a1),    .prod(aa3));
  pcomp_mul64 u_ap5 (.clk(clk), .a(a1),   .b(sx_p5), .prod(ap5_3));
  pcomp_mul64 u_ap2 (.clk(clk), .a(a1),   .b(sx_p2), .prod(ap2_3));
  pcomp_mul64 u_m6  (.clk(clk), .a(aa3),  .b(sx_p6), .prod(m6_5));
  pcomp_mul64 u_m3  (.clk(clk), .a(aa3),  .b(sx_p3), .prod(m3_5));
  pcomp_mul64 u_d   (.clk(clk), .a(vv6),  .b(zx_p1), .prod(dprod8));
  pcomp_mul64 u_n   (.clk(clk), .a(num7), .b(Scale), .prod(n9));

  logic  qv, qz;
  word_t pq;

  pcomp_div u_div (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (vpre[9]),
    .in_zero (d9 == '0),
    .num     (n9),
    .den     (d9),
    .out_vld (qv),
    .out_zero(qz),
    .quo     (pq)
  );

  // back end: correction terms, scaling to milli-pascals
  word_t      q_sh, q76, q77, mq9, mp8, ma9, b78, b79;
  word_t      p76, p77, p78, p79, s80, pf81;
  logic [5:0] vpost;
  logic [5:0] zpost;
  logic [31:0] res;
  logic [14:0] frac_prod;

  assign q_sh = word_t'($signed(pq) >>> 13);

  pcomp_mul64 u_q9 (.clk(clk), .a(q_sh), .b(sx_p9), .prod(mq9));
  pcomp_mul64 u_p8 (.clk(clk), .a(pq),   .b(sx_p8), .prod(mp8));
  pcomp_mul64 u_a9 (.clk(clk), .a(mq9),  .b(q77),   .prod(ma9));

  // 390625 / 100000 is exactly 125 / 32
  assign frac_prod = {7'd0, pf81[7:0]} * 15'd125;
  assign res = pf81[39:8] * 32'd1000 + {22'd0, frac_prod[14:5]};

  always_ff @(posedge clk) begin
    if (rst) begin
      vpost <= '0;
      done  <= 1'b0;
    end else begin
      vpost <= {vpost[4:0], qv};
      done  <= vpost[5];
    end
    zpost <= {zpost[4:0], qz};
    q76   <= q_sh;
    q77   <= q76;
    p76   <= pq;
    p77   <= p76;
    p78   <= p77;
    p79   <= p78;
    b78   <= word_t'($signed(mp8) >>> 19);
    b79   <= b78;
    s80   <= p79 + word_t'($signed(ma9) >>> 25) + b79;
    pf81  <= word_t'($signed(s80) >>> 8) + (sx_p7 << 4);
    pressure_milli_pa <= zpost[5] ? 32'd0 : res;
    zero_divisor      <= zpost[5];
  end

endmodule
